// ----- design/scc_pkg.sv -----
// ----------------------------------------------------------------------------
// scc_pkg: shared types for the strongly connected components block
// Beat layouts of the edge input channel and the result output channel.
// ----------------------------------------------------------------------------
`default_nettype none

package scc_pkg;

    typedef struct packed {
        logic [3:0] from_node;
        logic [3:0] to_node;
        logic       both_ways;
        logic       last_edge;
    } edge_beat_t;

    typedef struct packed {
        logic [3:0] node_id;
        logic [3:0] component;
        logic [4:0] component_count;
        logic       edges_dropped;
        logic       last_result;
    } result_beat_t;

endpackage

`default_nettype wire

// ----- design/scc_ram.sv -----
// ----------------------------------------------------------------------------
// scc_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module scc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

`default_nettype wire

// ----- design/strongly_connected_components.sv -----
// ----------------------------------------------------------------------------
// strongly_connected_components: Kosaraju SCC over a small directed graph
// Loads edges into a RAM, then runs two depth-first passes with one sequencer.
// ----------------------------------------------------------------------------
// Edge beats are taken one per cycle; a both_ways edge holds the input while
// its reverse is written (S_LOAD2). After the beat marked last_edge the input
// stalls while the sequencer walks the graph: every edge examined takes an edge
// RAM read (S_WALK_RD), then a compare (S_WALK_CHK), and each node on the walk
// stack scans the stored edges once per pass. Then one result beat per node is
// issued in ascending order, one per cycle when the sink does not stall.
// Edge store and overflow flag clear as the final result beat is loaded.
`default_nettype none

module strongly_connected_components #(
    parameter int MAX_NODES = 16,
    parameter int MAX_EDGES = 64
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_wen,
    input  wire logic [4:0]            cfg_wdata,
    input  wire logic                  edge_valid,
    output logic                       edge_stall,
    input  wire scc_pkg::edge_beat_t   edge_beat,
    output logic                       result_valid,
    input  wire logic                  result_stall,
    output scc_pkg::result_beat_t      result_beat
);

    import scc_pkg::*;

    localparam int SLOTS = (MAX_NODES < 31) ? MAX_NODES : 31;
    localparam int NW    = $clog2(SLOTS);
    localparam int DW    = $clog2(SLOTS + 1);
    localparam int AW    = $clog2(MAX_EDGES);
    localparam int EW    = $clog2(MAX_EDGES + 1);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_LOAD2    = 3'd1;
    localparam logic [2:0] S_OUTER    = 3'd2;
    localparam logic [2:0] S_WALK_RD  = 3'd3;
    localparam logic [2:0] S_WALK_CHK = 3'd4;
    localparam logic [2:0] S_EMIT     = 3'd5;

    logic [2:0]         state_reg, state_next;
    logic [4:0]         node_count_reg, node_count_next;
    logic [EW-1:0]      cnt_reg, cnt_next;
    logic               ovf_reg, ovf_next;
    logic               last_reg, last_next;
    logic [7:0]         rev_reg, rev_next;
    logic               pass_reg, pass_next;
    logic [SLOTS-1:0]   visited_reg, visited_next;
    logic [4:0]         v_reg, v_next;
    logic [DW-1:0]      depth_reg, depth_next;
    logic [DW-1:0]      flen_reg, flen_next;
    logic [DW-1:0]      fidx_reg, fidx_next;
    logic [4:0]         count_reg, count_next;
    logic [EW-1:0]      cur_reg, cur_next;
    logic [4:0]         e_reg, e_next;
    logic               rvalid_reg, rvalid_next;
    result_beat_t       rbeat_reg, rbeat_next;

    logic [NW-1:0]      stack_node_reg [SLOTS];
    logic [NW-1:0]      stack_node_next [SLOTS];
    logic [EW-1:0]      stack_cur_reg [SLOTS];
    logic [EW-1:0]      stack_cur_next [SLOTS];
    logic [NW-1:0]      finish_reg [SLOTS];
    logic [NW-1:0]      finish_next [SLOTS];
    logic [3:0]         comp_reg [SLOTS];
    logic [3:0]         comp_next [SLOTS];

    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [7:0]         ram_wdata;
    logic [AW-1:0]      ram_raddr;
    logic [7:0]         ram_rdata;

    logic [4:0]         n_act;
    logic [NW-1:0]      top_idx;
    logic [NW-1:0]      top_node;
    logic [EW-1:0]      top_cur;
    logic [4:0]         here, there;
    logic               follow;
    logic               start_walk;
    logic [NW-1:0]      start_node;
    logic               in_range;
    logic [NW-1:0]      fnode;

    scc_ram #(
        .WIDTH (8),
        .DEPTH (MAX_EDGES)
    ) u_edges (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign n_act = (node_count_reg > 5'(SLOTS)) ? 5'(SLOTS) : node_count_reg;
    assign top_idx  = NW'(depth_reg - DW'(1));
    assign top_node = stack_node_reg[top_idx];
    assign top_cur  = stack_cur_reg[top_idx];

    // pass one follows edges forward, pass two follows them reversed
    assign here  = pass_reg ? {1'b0, ram_rdata[3:0]} : {1'b0, ram_rdata[7:4]};
    assign there = pass_reg ? {1'b0, ram_rdata[7:4]} : {1'b0, ram_rdata[3:0]};
    assign follow = (here == 5'(top_node)) && (there < n_act) && (here < n_act)
                    && !visited_reg[there[NW-1:0]];

    assign in_range = ({1'b0, edge_beat.from_node} < node_count_reg)
                      && ({1'b0, edge_beat.to_node} < node_count_reg);
    assign fnode = finish_reg[NW'(fidx_reg - DW'(1))];

    assign edge_stall   = (state_reg != S_IDLE);
    assign result_valid = rvalid_reg;
    assign result_beat  = rbeat_reg;

    always_comb
    begin
        state_next      = state_reg;
        node_count_next = cfg_wen ? cfg_wdata : node_count_reg;
        cnt_next        = cnt_reg;
        ovf_next        = ovf_reg;
        last_next       = last_reg;
        rev_next        = rev_reg;
        pass_next       = pass_reg;
        visited_next    = visited_reg;
        v_next          = v_reg;
        depth_next      = depth_reg;
        flen_next       = flen_reg;
        fidx_next       = fidx_reg;
        count_next      = count_reg;
        cur_next        = cur_reg;
        e_next          = e_reg;
        rvalid_next     = rvalid_reg;
        rbeat_next      = rbeat_reg;
        stack_node_next = stack_node_reg;
        stack_cur_next  = stack_cur_reg;
        finish_next     = finish_reg;
        comp_next       = comp_reg;
        ram_we          = 1'b0;
        ram_waddr       = cnt_reg[AW-1:0];
        ram_wdata       = {edge_beat.from_node, edge_beat.to_node};
        ram_raddr       = top_cur[AW-1:0];
        start_walk      = 1'b0;
        start_node      = v_reg[NW-1:0];

        if (rvalid_reg && !result_stall)
        begin
            rvalid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (edge_valid)
                begin
                    if (in_range)
                    begin
                        if (cnt_reg < EW'(MAX_EDGES))
                        begin
                            ram_we   = 1'b1;
                            cnt_next = cnt_reg + EW'(1);
                        end
                        else
                        begin
                            ovf_next = 1'b1;
                        end
                    end
                    rev_next  = {edge_beat.to_node, edge_beat.from_node};
                    last_next = edge_beat.last_edge;
                    if (in_range && edge_beat.both_ways)
                    begin
                        state_next = S_LOAD2;
                    end
                    else if (edge_beat.last_edge)
                    begin
                        state_next   = S_OUTER;
                        pass_next    = 1'b0;
                        visited_next = '0;
                        flen_next    = '0;
                        v_next       = '0;
                        e_next       = '0;
                    end
                end
            end
            S_LOAD2:
            begin
                ram_wdata = rev_reg;
                if (cnt_reg < EW'(MAX_EDGES))
                begin
                    ram_we   = 1'b1;
                    cnt_next = cnt_reg + EW'(1);
                end
                else
                begin
                    ovf_next = 1'b1;
                end
                if (last_reg)
                begin
                    state_next   = S_OUTER;
                    pass_next    = 1'b0;
                    visited_next = '0;
                    flen_next    = '0;
                    v_next       = '0;
                    e_next       = '0;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_OUTER:
            begin
                if (!pass_reg)
                begin
                    if (v_reg >= n_act)
                    begin
                        pass_next    = 1'b1;
                        visited_next = '0;
                        fidx_next    = flen_reg;
                        count_next   = '0;
                    end
                    else if (visited_reg[v_reg[NW-1:0]])
                    begin
                        v_next = v_reg + 5'd1;
                    end
                    else
                    begin
                        start_walk = 1'b1;
                        start_node = v_reg[NW-1:0];
                    end
                end
                else
                begin
                    if (fidx_reg == '0)
                    begin
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        fidx_next = fidx_reg - DW'(1);
                        if (!visited_reg[fnode])
                        begin
                            start_walk = 1'b1;
                            start_node = fnode;
                        end
                    end
                end
            end
            S_WALK_RD:
            begin
                if (top_cur >= cnt_reg)
                begin
                    // node finished: pop it
                    if (!pass_reg && (flen_reg < DW'(SLOTS)))
                    begin
                        finish_next[flen_reg[NW-1:0]] = top_node;
                        flen_next = flen_reg + DW'(1);
                    end
                    depth_next = depth_reg - DW'(1);
                    if (depth_reg == DW'(1))
                    begin
                        state_next = S_OUTER;
                        if (pass_reg)
                        begin
                            count_next = count_reg + 5'd1;
                        end
                    end
                end
                else
                begin
                    cur_next   = top_cur;
                    state_next = S_WALK_CHK;
                end
            end
            S_WALK_CHK:
            begin
                stack_cur_next[top_idx] = cur_reg + EW'(1);
                if (follow && (depth_reg < DW'(SLOTS)))
                begin
                    stack_node_next[depth_reg[NW-1:0]] = there[NW-1:0];
                    stack_cur_next[depth_reg[NW-1:0]]  = '0;
                    depth_next = depth_reg + DW'(1);
                    visited_next[there[NW-1:0]] = 1'b1;
                    if (pass_reg)
                    begin
                        comp_next[there[NW-1:0]] = count_reg[3:0];
                    end
                end
                state_next = S_WALK_RD;
            end
            S_EMIT:
            begin
                if (n_act == '0)
                begin
                    cnt_next   = '0;
                    ovf_next   = 1'b0;
                    state_next = S_IDLE;
                end
                else if (!rvalid_reg || !result_stall)
                begin
                    rvalid_next                = 1'b1;
                    rbeat_next.node_id         = e_reg[3:0];
                    rbeat_next.component       = comp_reg[e_reg[NW-1:0]];
                    rbeat_next.component_count = count_reg;
                    rbeat_next.edges_dropped   = ovf_reg;
                    rbeat_next.last_result     = (e_reg + 5'd1 == n_act);
                    e_next = e_reg + 5'd1;
                    if (e_reg + 5'd1 == n_act)
                    begin
                        cnt_next   = '0;
                        ovf_next   = 1'b0;
                        e_next     = '0;
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (start_walk)
        begin
            stack_node_next[0]       = start_node;
            stack_cur_next[0]        = '0;
            depth_next               = DW'(1);
            visited_next[start_node] = 1'b1;
            if (pass_reg)
            begin
                comp_next[start_node] = count_reg[3:0];
            end
            state_next = S_WALK_RD;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            node_count_reg <= 5'd16;
            cnt_reg        <= '0;
            ovf_reg        <= 1'b0;
            last_reg       <= 1'b0;
            pass_reg       <= 1'b0;
            visited_reg    <= '0;
            v_reg          <= '0;
            depth_reg      <= '0;
            flen_reg       <= '0;
            fidx_reg       <= '0;
            count_reg      <= '0;
            cur_reg        <= '0;
            e_reg          <= '0;
            rvalid_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            node_count_reg <= node_count_next;
            cnt_reg        <= cnt_next;
            ovf_reg        <= ovf_next;
            last_reg       <= last_next;
            pass_reg       <= pass_next;
            visited_reg    <= visited_next;
            v_reg          <= v_next;
            depth_reg      <= depth_next;
            flen_reg       <= flen_next;
            fidx_reg       <= fidx_next;
            count_reg      <= count_next;
            cur_reg        <= cur_next;
            e_reg          <= e_next;
            rvalid_reg     <= rvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rev_reg        <= rev_next;
        rbeat_reg      <= rbeat_next;
        stack_node_reg <= stack_node_next;
        stack_cur_reg  <= stack_cur_next;
        finish_reg     <= finish_next;
        comp_reg       <= comp_next;
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= EW'(MAX_EDGES))
        else $error("edge count beyond store size");

    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= DW'(SLOTS))
        else $error("walk stack overrun");

    a_walk_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK_RD || state_reg == S_WALK_CHK) |-> depth_reg != '0)
        else $error("walk with empty stack");

    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT && rvalid_next && rbeat_next.last_result
         && (!rvalid_reg || !result_stall)) |=> (cnt_reg == '0 && !ovf_reg))
        else $error("edge store not cleared after final result");

endmodule

`default_nettype wire
